/* design/tbkn_pkg.sv */
// Shared types and constants for the touch button k-of-n qualifier.
// No dependencies; imported by tbkn_history and the core top level.
package tbkn_pkg;

  localparam int unsigned ChannelW            = 3;
  localparam int unsigned LevelW              = 16;
  localparam int unsigned LevelRegs           = 6;
  localparam int unsigned CfgIndexW           = 3;
  localparam int unsigned HistoryDepthDefault = 8;
  localparam int unsigned ChannelsDefault     = 6;
  localparam int unsigned PressCount          = 3;
  localparam logic [LevelW:0] TouchMargin     = 17'd5;

  typedef enum logic {
    CmdSample = 1'b0,
    CmdPoll   = 1'b1
  } cmd_t;

  typedef struct packed {
    logic                fire;
    cmd_t                cmd;
    logic [ChannelW-1:0] channel;
    logic                touched;
  } hist_req_t;

endpackage

/* design/touch_button_k_of_n_qualifier_core.sv */
// Top level of the touch button k-of-n qualifier: idle levels, input and result registers.
// Depends on tbkn_pkg and tbkn_history.
//
//   channel  | signals                            | beat
//   ---------+------------------------------------+-----------------------------
//   config   | cfg_we, cfg_index, cfg_data        | write when cfg_we is high
//   input    | in_valid/in_ready: cmd, channel,   | in_valid && in_ready
//            | reading                            |
//   result   | out_valid/out_ready: is_pressed    | out_valid && out_ready
//
// One beat per cycle while no poll is held back by a stalled result register. A
// beat waits in the input register, where the compare and history update run; a
// poll then moves on into the result register, a sample yields nothing.
// Synchronous reset clears histories, positions, counts, idle levels and both valid flags.
// A poll waiting on a full, stalled result register holds the input register.
module touch_button_k_of_n_qualifier_core #(
  parameter int unsigned HISTORY_DEPTH = tbkn_pkg::HistoryDepthDefault,
  parameter int unsigned CHANNELS      = tbkn_pkg::ChannelsDefault
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [tbkn_pkg::CfgIndexW-1:0] cfg_index,
  input  logic [tbkn_pkg::LevelW-1:0]    cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           cmd,
  input  logic [tbkn_pkg::ChannelW-1:0]  channel,
  input  logic [tbkn_pkg::LevelW-1:0]    reading,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           is_pressed
);
  import tbkn_pkg::*;

  logic [LevelW-1:0]   idle_level[LevelRegs];

  logic                s1_valid;
  cmd_t                s1_cmd;
  logic [ChannelW-1:0] s1_channel;
  logic [LevelW-1:0]   s1_reading;

  logic [LevelW-1:0]   level_sel;
  logic                touched;
  logic                advance;
  logic                pressed;
  hist_req_t           req;

  always_comb begin
    level_sel = (int'(s1_channel) < int'(LevelRegs)) ? idle_level[s1_channel] : '0;
    touched   = ({1'b0, s1_reading} + TouchMargin) < {1'b0, level_sel};
    advance   = s1_valid && (s1_cmd == CmdSample || !out_valid || out_ready);
    in_ready  = !s1_valid || advance;
    req.fire    = advance;
    req.cmd     = s1_cmd;
    req.channel = s1_channel;
    req.touched = touched;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < int'(LevelRegs); i++) begin
        idle_level[i] <= '0;
      end
    end else if (cfg_we && int'(cfg_index) < int'(LevelRegs)) begin
      idle_level[cfg_index] <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
    if (in_valid && in_ready) begin
      s1_cmd     <= cmd_t'(cmd);
      s1_channel <= channel;
      s1_reading <= reading;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && s1_cmd == CmdPoll) begin
      out_valid <= 1'b1;
    end else if (out_valid && out_ready) begin
      out_valid <= 1'b0;
    end
    if (advance && s1_cmd == CmdPoll) begin
      is_pressed <= pressed;
    end
  end

  tbkn_history #(
    .HISTORY_DEPTH(HISTORY_DEPTH),
    .CHANNELS     (CHANNELS)
  ) u_history (
    .clk    (clk),
    .rst    (rst),
    .req    (req),
    .pressed(pressed)
  );

endmodule

/* design/tbkn_history.sv */
// Per-channel touch history, write position and running touched count.
// Depends on tbkn_pkg for the request struct and press threshold.
module tbkn_history #(
  parameter int unsigned HISTORY_DEPTH = tbkn_pkg::HistoryDepthDefault,
  parameter int unsigned CHANNELS      = tbkn_pkg::ChannelsDefault
) (
  input  logic                clk,
  input  logic                rst,
  input  tbkn_pkg::hist_req_t req,
  output logic                pressed
);
  import tbkn_pkg::*;

  localparam int unsigned PosW = $clog2(HISTORY_DEPTH);
  localparam int unsigned CntW = $clog2(HISTORY_DEPTH + 1);
  localparam int unsigned IdxW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam logic [PosW-1:0] PosLast = PosW'(HISTORY_DEPTH - 1);

  logic [HISTORY_DEPTH-1:0] history [CHANNELS];
  logic [PosW-1:0]          position[CHANNELS];
  logic [CntW-1:0]          count   [CHANNELS];

  logic                     in_range;
  logic [IdxW-1:0]          idx;
  logic [HISTORY_DEPTH-1:0] cur_hist;
  logic [PosW-1:0]          cur_pos;
  logic [CntW-1:0]          cur_cnt;
  logic                     old_bit;
  logic                     hit;
  logic [CntW-1:0]          count_next;
  logic [PosW-1:0]          position_next;

  always_comb begin
    in_range      = int'(req.channel) < int'(CHANNELS);
    idx           = req.channel[IdxW-1:0];
    cur_hist      = history[idx];
    cur_pos       = position[idx];
    cur_cnt       = count[idx];
    old_bit       = cur_hist[cur_pos];
    hit           = cur_cnt >= CntW'(PressCount);
    pressed       = in_range && hit;
    count_next    = cur_cnt - CntW'(old_bit) + CntW'(req.touched);
    position_next = (cur_pos == PosLast) ? '0 : cur_pos + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < int'(CHANNELS); i++) begin
        history[i]  <= '0;
        position[i] <= '0;
        count[i]    <= '0;
      end
    end else if (req.fire && in_range) begin
      if (req.cmd == CmdSample) begin
        history[idx][cur_pos] <= req.touched;
        position[idx]         <= position_next;
        count[idx]            <= count_next;
      end else if (hit) begin
        history[idx] <= '0;
        count[idx]   <= '0;
      end
    end
  end

endmodule
